// ----- rtl/core/mset_pkg.sv -----
// Shared types, constants and codes for the MIPS subset execute block.
`timescale 1ns / 1ps

package mset_pkg;

	// Memory geometry
	localparam int MEM_WORDS  = 262144;
	localparam int ROW_BYTES  = 1024;
	localparam int WORD_W     = $clog2(MEM_WORDS);
	localparam int ADDR_W     = WORD_W + 2;
	localparam int ROW_SHIFT  = $clog2(ROW_BYTES);
	localparam int ROW_W      = (ADDR_W > ROW_SHIFT) ? ADDR_W - ROW_SHIFT : 1;
	localparam logic [31:0] BYTE_LIMIT = 32'(MEM_WORDS * 4);

	// Field widths
	localparam int XLEN     = 32;
	localparam int RF_DEPTH = 32;
	localparam int REG_W    = 5;
	localparam int PC_W     = 16;
	localparam int DLY_W    = 8;
	localparam int LAT_W    = 10;

	// Reset values of the timing registers
	localparam logic [DLY_W-1:0] ROW_DELAY_RST = 8'd10;
	localparam logic [DLY_W-1:0] COL_DELAY_RST = 8'd2;

	// Reserved destinations for ALU ops
	localparam logic [REG_W-1:0] RSV_ZERO = 5'd0;
	localparam logic [REG_W-1:0] RSV_AT   = 5'd1;
	localparam logic [REG_W-1:0] RSV_K1   = 5'd27;

	typedef enum logic [3:0] {
		OP_ADD  = 4'd0,
		OP_SUB  = 4'd1,
		OP_MUL  = 4'd2,
		OP_SLT  = 4'd3,
		OP_ADDI = 4'd4,
		OP_BEQ  = 4'd5,
		OP_BNE  = 4'd6,
		OP_J    = 4'd7,
		OP_LW   = 4'd8,
		OP_SW   = 4'd9
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_ADDR = 2'd1,
		ST_OVERFLOW = 2'd2,
		ST_RSV_DEST = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ROW_HIT      = 2'd0,
		ROW_COLD     = 2'd1,
		ROW_CONFLICT = 2'd2
	} row_res_t;

	typedef enum logic [0:0] {
		CFG_ROW_DELAY = 1'b0,
		CFG_COL_DELAY = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [3:0]              operation;
		logic [REG_W-1:0]        dest_index;
		logic [REG_W-1:0]        src1_index;
		logic [REG_W-1:0]        src2_index;
		logic signed [XLEN-1:0]  immediate;
		logic [PC_W-1:0]         target;
	} instr_t;

	typedef struct packed {
		logic [PC_W-1:0]         next_pc;
		logic                    write_enable;
		logic [REG_W-1:0]        write_index;
		logic signed [XLEN-1:0]  write_value;
		logic [1:0]              status;
		logic                    dram_access;
		logic [1:0]              row_result;
		logic [LAT_W-1:0]        dram_latency;
		logic [31:0]             row_updates;
	} result_t;

	// Register file read request: a = src1, b = src2, c = dest
	typedef struct packed {
		logic             en;
		logic [REG_W-1:0] a;
		logic [REG_W-1:0] b;
		logic [REG_W-1:0] c;
	} rf_rd_t;

	typedef struct packed {
		logic [XLEN-1:0] a;
		logic [XLEN-1:0] b;
		logic [XLEN-1:0] c;
	} rf_data_t;

	typedef struct packed {
		logic             en;
		logic [REG_W-1:0] idx;
		logic [XLEN-1:0]  data;
	} rf_wr_t;

	typedef struct packed {
		logic              en;
		logic [WORD_W-1:0] addr;
	} dm_rd_t;

	typedef struct packed {
		logic              en;
		logic [WORD_W-1:0] addr;
		logic [XLEN-1:0]   data;
	} dm_wr_t;

endpackage

// ----- rtl/core/mset_if.sv -----
// Valid/ready channel interfaces for instructions and results.
`timescale 1ns / 1ps

interface mset_instr_if import mset_pkg::*; ();
	logic   valid;
	logic   ready;
	instr_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface mset_result_if import mset_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/mset_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mset_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/mset_regfile.sv -----
// Register file: three read copies, per-entry valid bits, write forwarding.
`timescale 1ns / 1ps

module mset_regfile import mset_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  rf_rd_t   rd,
	input  rf_wr_t   wr,
	output rf_data_t data
);

	logic [RF_DEPTH-1:0] valid_q;
	logic [REG_W-1:0]    a_q, b_q, c_q;
	logic                fwd_en_q;
	logic [REG_W-1:0]    fwd_idx_q;
	logic [XLEN-1:0]     fwd_data_q;
	rf_data_t            ram_q;

	mset_ram #(.WIDTH(XLEN), .DEPTH(RF_DEPTH)) u_ram_a (
		.clk(clk), .we(wr.en), .waddr(wr.idx), .wdata(wr.data),
		.re(rd.en), .raddr(rd.a), .rdata(ram_q.a)
	);
	mset_ram #(.WIDTH(XLEN), .DEPTH(RF_DEPTH)) u_ram_b (
		.clk(clk), .we(wr.en), .waddr(wr.idx), .wdata(wr.data),
		.re(rd.en), .raddr(rd.b), .rdata(ram_q.b)
	);
	mset_ram #(.WIDTH(XLEN), .DEPTH(RF_DEPTH)) u_ram_c (
		.clk(clk), .we(wr.en), .waddr(wr.idx), .wdata(wr.data),
		.re(rd.en), .raddr(rd.c), .rdata(ram_q.c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			fwd_en_q <= 1'b0;
		end else if (wr.en) begin
			valid_q[wr.idx] <= 1'b1;
			fwd_en_q        <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			a_q <= rd.a;
			b_q <= rd.b;
			c_q <= rd.c;
		end
		if (wr.en) begin
			fwd_idx_q  <= wr.idx;
			fwd_data_q <= wr.data;
		end
	end

	// Latest write wins over a same-edge read; never-written entries read zero.
	always_comb begin
		data.a = (fwd_en_q && fwd_idx_q == a_q) ? fwd_data_q :
		         (valid_q[a_q] ? ram_q.a : '0);
		data.b = (fwd_en_q && fwd_idx_q == b_q) ? fwd_data_q :
		         (valid_q[b_q] ? ram_q.b : '0);
		data.c = (fwd_en_q && fwd_idx_q == c_q) ? fwd_data_q :
		         (valid_q[c_q] ? ram_q.c : '0);
	end

endmodule

// ----- rtl/core/mset_dmem.sv -----
// Data memory: clearing sweep after reset, one read port, write forwarding.
`timescale 1ns / 1ps

module mset_dmem import mset_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  dm_rd_t          rd,
	input  dm_wr_t          wr,
	output logic [XLEN-1:0] rdata,
	output logic            clear_done
);

	logic [WORD_W-1:0] clr_addr_q;
	logic              done_q;
	logic [WORD_W-1:0] raddr_q;
	logic              fwd_en_q;
	logic [WORD_W-1:0] fwd_addr_q;
	logic [XLEN-1:0]   fwd_data_q;
	logic [XLEN-1:0]   ram_q;
	logic              ram_we;
	logic [WORD_W-1:0] ram_waddr;
	logic [XLEN-1:0]   ram_wdata;

	always_comb begin
		ram_we    = !done_q || wr.en;
		ram_waddr = done_q ? wr.addr : clr_addr_q;
		ram_wdata = done_q ? wr.data : '0;
	end

	mset_ram #(.WIDTH(XLEN), .DEPTH(MEM_WORDS)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.re(rd.en), .raddr(rd.addr), .rdata(ram_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			done_q     <= 1'b0;
			fwd_en_q   <= 1'b0;
		end else begin
			if (!done_q) begin
				clr_addr_q <= clr_addr_q + WORD_W'(1);
				if (clr_addr_q == WORD_W'(MEM_WORDS - 1)) begin
					done_q <= 1'b1;
				end
			end
			if (done_q && wr.en) begin
				fwd_en_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			raddr_q <= rd.addr;
		end
		if (wr.en) begin
			fwd_addr_q <= wr.addr;
			fwd_data_q <= wr.data;
		end
	end

	assign rdata      = (fwd_en_q && fwd_addr_q == raddr_q) ? fwd_data_q : ram_q;
	assign clear_done = done_q;

endmodule

// ----- rtl/core/mips_subset_execute_dram_timing.sv -----
// Top level: execute stage of a small MIPS subset with a DRAM open-row timing model.
`timescale 1ns / 1ps
//
// Channel   Dir  Handshake          Payload
// --------  ---  -----------------  ----------------------------------------------
// instr     in   valid/ready        operation, indices, immediate, target
// result    out  valid/ready        next_pc, write, status, DRAM row outcome/count
// cfg       in   cfg_write (no ack) cfg_index (0 row delay, 1 col delay), cfg_data
//
// One instruction per cycle while results are taken. An accepted transaction reads the
// register file copies and the data memory at once (s1 gets the data next cycle), then
// s1 computes and writes back as it moves into the output register (s2).
// Same-entry read/write overlap is covered by forwarding in both memories.
// After reset the data memory is swept to zero, one word per cycle, with instr.ready
// low. A stalled result holds s2; s1 still fills behind it.
//

module mips_subset_execute_dram_timing import mset_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	mset_instr_if.sink         instr,
	mset_result_if.source      result,
	input  logic               cfg_write,
	input  logic [0:0]         cfg_index,
	input  logic [DLY_W-1:0]   cfg_data
);

	// Timing configuration
	logic [DLY_W-1:0] row_delay_q;
	logic [DLY_W-1:0] col_delay_q;

	// Architectural state kept in flops
	logic [PC_W-1:0]  pc_q;
	logic [ROW_W-1:0] open_row_q;
	logic             row_open_q;
	logic [31:0]      row_upd_q;

	// Pipeline
	logic    valid_s1;
	instr_t  instr_s1;
	logic    valid_s2;
	result_t result_s2;
	logic    adv_s1;
	logic    accept;
	logic    clear_done;

	// Memory side
	rf_rd_t          rf_rd;
	rf_wr_t          rf_wr;
	rf_data_t        rf_data;
	dm_rd_t          dm_rd;
	dm_wr_t          dm_wr;
	logic [XLEN-1:0] dm_rdata;

	// Execute logic
	op_t                  op;
	logic [XLEN-1:0]      imm_u;
	logic [XLEN:0]        sum;
	logic [XLEN:0]        diff;
	logic [XLEN:0]        addi_sum;
	logic signed [2*XLEN-1:0] prod;
	logic                 less;
	logic [XLEN-1:0]      alu_val;
	logic                 alu_ovf;
	logic                 rsv_dest;
	logic                 addr_ok;
	logic [ROW_W-1:0]     row;
	logic [LAT_W-1:0]     row_lat;
	logic [LAT_W-1:0]     col_lat;
	result_t              res_d;
	logic [ROW_W-1:0]     open_row_d;
	logic                 row_open_d;
	logic [31:0]          row_upd_d;

	//------------------------------------------------------------------
	// Configuration
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_delay_q <= ROW_DELAY_RST;
			col_delay_q <= COL_DELAY_RST;
		end else if (cfg_write) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ROW_DELAY: row_delay_q <= cfg_data;
				CFG_COL_DELAY: col_delay_q <= cfg_data;
				default: ;
			endcase
		end
	end

	//------------------------------------------------------------------
	// Handshake and pipeline control
	//------------------------------------------------------------------
	assign adv_s1      = valid_s1 && (!valid_s2 || result.ready);
	assign instr.ready = clear_done && (!valid_s1 || adv_s1);
	assign accept      = instr.valid && instr.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			instr_s1 <= instr.payload;
		end
		if (adv_s1) begin
			result_s2 <= res_d;
		end
	end

	assign result.valid   = valid_s2;
	assign result.payload = result_s2;

	//------------------------------------------------------------------
	// Memories: reads issue on accept, writes retire on s1 advance
	//------------------------------------------------------------------
	always_comb begin
		rf_rd.en = accept;
		rf_rd.a  = instr.payload.src1_index;
		rf_rd.b  = instr.payload.src2_index;
		rf_rd.c  = instr.payload.dest_index;
		dm_rd.en   = accept;
		dm_rd.addr = WORD_W'(32'(instr.payload.immediate) >> 2);
	end

	mset_regfile u_regfile (
		.clk(clk), .arst_n(arst_n), .rd(rf_rd), .wr(rf_wr), .data(rf_data)
	);

	mset_dmem u_dmem (
		.clk(clk), .arst_n(arst_n), .rd(dm_rd), .wr(dm_wr),
		.rdata(dm_rdata), .clear_done(clear_done)
	);

	//------------------------------------------------------------------
	// Execute (s1)
	//------------------------------------------------------------------
	always_comb begin
		op       = op_t'(instr_s1.operation);
		imm_u    = instr_s1.immediate;
		sum      = {rf_data.a[XLEN-1], rf_data.a} + {rf_data.b[XLEN-1], rf_data.b};
		diff     = {rf_data.a[XLEN-1], rf_data.a} - {rf_data.b[XLEN-1], rf_data.b};
		addi_sum = {rf_data.a[XLEN-1], rf_data.a} + {imm_u[XLEN-1], imm_u};
		prod     = $signed(rf_data.a) * $signed(rf_data.b);
		less     = $signed(rf_data.a) < $signed(rf_data.b);
		rsv_dest = (instr_s1.dest_index == RSV_ZERO) || (instr_s1.dest_index == RSV_AT)
		        || (instr_s1.dest_index == RSV_K1);
		addr_ok  = !imm_u[XLEN-1] && (imm_u[1:0] == 2'b00) && (imm_u < BYTE_LIMIT);
		row      = ROW_W'(imm_u >> ROW_SHIFT);
		row_lat  = LAT_W'(row_delay_q);
		col_lat  = LAT_W'(col_delay_q);

		// ALU result and signed overflow (exact result outside 32 bits)
		case (op)
			OP_ADD: begin
				alu_val = sum[XLEN-1:0];
				alu_ovf = sum[XLEN] != sum[XLEN-1];
			end
			OP_SUB: begin
				alu_val = diff[XLEN-1:0];
				alu_ovf = diff[XLEN] != diff[XLEN-1];
			end
			OP_MUL: begin
				alu_val = prod[XLEN-1:0];
				alu_ovf = !((&prod[2*XLEN-1:XLEN-1]) || !(|prod[2*XLEN-1:XLEN-1]));
			end
			OP_ADDI: begin
				alu_val = addi_sum[XLEN-1:0];
				alu_ovf = addi_sum[XLEN] != addi_sum[XLEN-1];
			end
			default: begin
				alu_val = XLEN'(less);
				alu_ovf = 1'b0;
			end
		endcase

		res_d.next_pc      = pc_q + PC_W'(1);
		res_d.write_enable = 1'b0;
		res_d.write_index  = '0;
		res_d.write_value  = '0;
		res_d.status       = ST_OK;
		res_d.dram_access  = 1'b0;
		res_d.row_result   = ROW_HIT;
		res_d.dram_latency = '0;
		open_row_d = open_row_q;
		row_open_d = row_open_q;
		row_upd_d  = row_upd_q;
		rf_wr.en   = 1'b0;
		rf_wr.idx  = instr_s1.dest_index;
		rf_wr.data = alu_val;
		dm_wr.en   = 1'b0;
		dm_wr.addr = WORD_W'(imm_u >> 2);
		dm_wr.data = rf_data.c;

		unique case (op) inside
			OP_ADD, OP_SUB, OP_MUL, OP_SLT, OP_ADDI: begin
				if (rsv_dest) begin
					res_d.status = ST_RSV_DEST;
				end else if (alu_ovf) begin
					res_d.status = ST_OVERFLOW;
				end else begin
					res_d.write_enable = 1'b1;
					res_d.write_index  = instr_s1.dest_index;
					res_d.write_value  = alu_val;
					rf_wr.en           = adv_s1;
				end
			end
			OP_BEQ, OP_BNE: begin
				if ((op == OP_BEQ) == (rf_data.c == rf_data.a)) begin
					res_d.next_pc = instr_s1.target;
				end
			end
			OP_J: begin
				res_d.next_pc = instr_s1.target;
			end
			OP_LW, OP_SW: begin
				if (!addr_ok) begin
					res_d.status = ST_BAD_ADDR;
				end else begin
					res_d.dram_access = 1'b1;
					if (!row_open_q) begin
						res_d.row_result   = ROW_COLD;
						res_d.dram_latency = row_lat + col_lat + LAT_W'(1);
						row_upd_d          = row_upd_q + 32'd1;
					end else if (open_row_q != row) begin
						res_d.row_result   = ROW_CONFLICT;
						res_d.dram_latency = (row_lat << 1) + col_lat + LAT_W'(1);
						row_upd_d          = row_upd_q + 32'd1;
					end else begin
						res_d.dram_latency = col_lat;
					end
					open_row_d = row;
					row_open_d = 1'b1;
					res_d.write_enable = 1'b1;
					res_d.write_index  = instr_s1.dest_index;
					if (op == OP_LW) begin
						res_d.write_value = dm_rdata;
						rf_wr.data        = dm_rdata;
						rf_wr.en          = adv_s1;
					end else begin
						res_d.write_value = rf_data.c;
						dm_wr.en          = adv_s1;
					end
				end
			end
			default: ;
		endcase

		res_d.row_updates = row_upd_d;
	end

	// Architectural state commits as s1 retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q       <= '0;
			open_row_q <= '0;
			row_open_q <= 1'b0;
			row_upd_q  <= '0;
		end else if (adv_s1) begin
			pc_q       <= res_d.next_pc;
			open_row_q <= open_row_d;
			row_open_q <= row_open_d;
			row_upd_q  <= row_upd_d;
		end
	end

	//------------------------------------------------------------------
	// Assertions
	//------------------------------------------------------------------
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!clear_done |-> !instr.ready)
		else $error("instruction taken during memory clear");

	a_count_only_on_retire: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(row_upd_q))
		else $error("row activation count moved without a retiring instruction");

	a_write_means_ok: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.write_enable |-> result_s2.status == ST_OK)
		else $error("write reported together with an error status");

	a_no_dram_no_latency: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !result_s2.dram_access |-> result_s2.dram_latency == '0)
		else $error("latency reported without a DRAM access");

	a_single_mem_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(rf_wr.en && dm_wr.en))
		else $error("register and memory written by one instruction");

endmodule

// ----- tb/mset_execute_compare.sv -----
// Predicts each instruction's result from the channel traffic and compares what the block returns.
`timescale 1ns / 1ps

module mset_execute_compare import mset_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	mset_instr_if            instr,
	mset_result_if           result,
	input  logic             cfg_write,
	input  logic [0:0]       cfg_index,
	input  logic [DLY_W-1:0] cfg_data,
	output int               mismatches,
	output int               pending
);

	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;

	// shadow architectural state
	logic [XLEN-1:0]  regs [RF_DEPTH];
	logic [XLEN-1:0]  data_words [int];
	logic [PC_W-1:0]  pc;
	logic [ROW_W-1:0] open_row;
	logic             row_open;
	logic [31:0]      activations;
	logic [DLY_W-1:0] row_dly;
	logic [DLY_W-1:0] col_dly;

	result_t predicted_results [$];
	result_t want;
	int      mismatch_count = 0;
	int      pending_count = 0;

	assign mismatches = mismatch_count;
	assign pending    = pending_count;

	function automatic result_t execute_instr(input instr_t ins);
		result_t           res;
		longint            a;
		longint            b;
		longint            imm;
		longint            sum;
		logic              ovf_check;
		logic [31:0]       addr;
		logic [ROW_W-1:0]  row;
		logic [WORD_W-1:0] word;
		int                lat;
		res = '0;
		res.next_pc = pc + 16'd1;
		a   = longint'($signed(regs[ins.src1_index]));
		b   = longint'($signed(regs[ins.src2_index]));
		imm = longint'($signed(ins.immediate));
		case (ins.operation)
			OP_ADD, OP_SUB, OP_MUL, OP_SLT, OP_ADDI: begin
				ovf_check = 1'b1;
				case (ins.operation)
					OP_ADD: sum = a + b;
					OP_SUB: sum = a - b;
					OP_MUL: sum = a * b;
					OP_SLT: begin
						sum = (a < b) ? 64'sd1 : 64'sd0;
						ovf_check = 1'b0;
					end
					default: sum = a + imm;
				endcase
				if (ins.dest_index inside {RSV_ZERO, RSV_AT, RSV_K1}) begin
					res.status = ST_RSV_DEST;
				end else if (ovf_check && (sum > S32_MAX || sum < S32_MIN)) begin
					res.status = ST_OVERFLOW;
				end else begin
					regs[ins.dest_index] = sum[31:0];
					res.write_enable = 1'b1;
					res.write_index  = ins.dest_index;
					res.write_value  = sum[31:0];
				end
			end
			OP_BEQ, OP_BNE: begin
				if ((ins.operation == OP_BEQ) == (regs[ins.dest_index] == regs[ins.src1_index]))
					res.next_pc = ins.target;
			end
			OP_J: res.next_pc = ins.target;
			OP_LW, OP_SW: begin
				if (imm < 0 || imm >= longint'(MEM_WORDS) * 4 || imm[1:0] != 2'b00) begin
					res.status = ST_BAD_ADDR;
				end else begin
					addr = imm[31:0];
					row  = addr[ROW_SHIFT +: ROW_W];
					word = addr[2 +: WORD_W];
					res.dram_access = 1'b1;
					if (!row_open) begin
						res.row_result = ROW_COLD;
						lat = row_dly + col_dly + 1;
						activations++;
					end else if (open_row != row) begin
						res.row_result = ROW_CONFLICT;
						lat = 2 * row_dly + col_dly + 1;
						activations++;
					end else begin
						res.row_result = ROW_HIT;
						lat = col_dly;
					end
					res.dram_latency = LAT_W'(lat);
					row_open = 1'b1;
					open_row = row;
					if (ins.operation == OP_LW) begin
						// never-written words read as zero (memory is swept at reset)
						res.write_value = data_words.exists(int'(word)) ? data_words[int'(word)] : '0;
						regs[ins.dest_index] = res.write_value;
					end else begin
						res.write_value = regs[ins.dest_index];
						data_words[int'(word)] = regs[ins.dest_index];
					end
					res.write_enable = 1'b1;
					res.write_index  = ins.dest_index;
				end
			end
			default: ;  // undefined codes only advance the pc
		endcase
		pc = res.next_pc;
		res.row_updates = activations;
		return res;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (exp_val !== act_val) begin
			mismatch_count++;
			$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
				$time, name, exp_val, act_val);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (regs[i]) regs[i] = '0;
			data_words.delete();
			pc          = '0;
			open_row    = '0;
			row_open    = 1'b0;
			activations = '0;
			row_dly     = ROW_DELAY_RST;
			col_dly     = COL_DELAY_RST;
			predicted_results.delete();
			pending_count = 0;
		end else begin
			if (cfg_write) begin
				if (cfg_index == CFG_ROW_DELAY)
					row_dly = cfg_data;
				else
					col_dly = cfg_data;
			end
			if (result.valid && result.ready) begin
				if (predicted_results.size() == 0) begin
					mismatch_count++;
					$display("%0t ns: result with none expected, actual %p", $time,
						result.payload);
				end else begin
					want = predicted_results.pop_front();
					check_field("next_pc", 32'(want.next_pc), 32'(result.payload.next_pc));
					check_field("write_enable", 32'(want.write_enable),
						32'(result.payload.write_enable));
					check_field("write_index", 32'(want.write_index),
						32'(result.payload.write_index));
					check_field("write_value", want.write_value, result.payload.write_value);
					check_field("status", 32'(want.status), 32'(result.payload.status));
					check_field("dram_access", 32'(want.dram_access),
						32'(result.payload.dram_access));
					check_field("row_result", 32'(want.row_result),
						32'(result.payload.row_result));
					check_field("dram_latency", 32'(want.dram_latency),
						32'(result.payload.dram_latency));
					check_field("row_updates", want.row_updates, result.payload.row_updates);
				end
			end
			if (instr.valid && instr.ready)
				predicted_results.insert(predicted_results.size(),
					execute_instr(instr.payload));
			pending_count = predicted_results.size();
		end
	end

endmodule

// ----- tb/mips_subset_execute_dram_timing_test.sv -----
// Stimulus, timing register phases and verdict for the execute stage with DRAM row timing.
`timescale 1ns / 1ps

module mips_subset_execute_dram_timing_test;
	import mset_pkg::*;

	// Undefined operation codes: the block must only advance the pc on these.
	localparam logic [3:0] OP_UNDEF_LO = 4'd10;
	localparam logic [3:0] OP_UNDEF_HI = 4'd15;

	localparam int NUM_PHASES    = 6;
	localparam int RANDOM_ITEMS  = 140;  // per timing phase
	localparam int SETTLE_CYCLES = 4;    // two-stage pipe, plus margin
	// The data memory sweep after reset keeps instr.ready low while it clears every word;
	// the limit covers that sweep four times over, far above any stall the stimulus makes.
	localparam int WATCHDOG_LIMIT = 4 * MEM_WORDS + 10000;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_write;
	logic [0:0]       cfg_index;
	logic [DLY_W-1:0] cfg_data;

	mset_instr_if  instr_ch ();
	mset_result_if result_ch ();

	int mismatches;
	int pending;
	int items_sent = 0;
	int results_seen = 0;
	int idle_cycles = 0;
	int row_hits = 0;
	int row_colds = 0;
	int row_conflicts = 0;
	int flagged = 0;
	logic [ROW_W-1:0] hot_row;

	mips_subset_execute_dram_timing i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.instr     (instr_ch),
		.result    (result_ch),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	mset_execute_compare i_compare (
		.clk        (clk),
		.arst_n     (arst_n),
		.instr      (instr_ch),
		.result     (result_ch),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Gap/stall length: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 85) return $urandom_range(1, 3);
		if (p < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic instr_t make_instr(input logic [3:0] op, input logic [REG_W-1:0] rd,
			input logic [REG_W-1:0] rs, input logic [REG_W-1:0] rt,
			input logic [31:0] imm, input logic [PC_W-1:0] tgt);
		instr_t x;
		x.operation  = op;
		x.dest_index = rd;
		x.src1_index = rs;
		x.src2_index = rt;
		x.immediate  = imm;
		x.target     = tgt;
		return x;
	endfunction

	// Random instruction. Loads/stores mostly hit a hot row and a few low words
	// so that row hits, conflicts and read-after-store all show up; the rest of
	// the addresses are full 32-bit noise (mostly invalid).
	function automatic instr_t random_instr();
		instr_t      x;
		int          pick;
		int unsigned row;
		int unsigned word_off;
		x.dest_index = REG_W'($urandom_range(0, 31));
		x.src1_index = REG_W'($urandom_range(0, 31));
		x.src2_index = REG_W'($urandom_range(0, 31));
		x.immediate  = $urandom;
		x.target     = PC_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 4) begin
			x.operation = 4'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
		end else if (pick < 36) begin
			x.operation = $urandom_range(0, 1) ? OP_LW : OP_SW;
			if ($urandom_range(0, 9) < 8) begin
				case ($urandom_range(0, 4))
					0, 1, 2: row = 32'(hot_row);
					3:       row = $urandom_range(0, 1) ? 0 : (MEM_WORDS * 4 / ROW_BYTES) - 1;
					default: row = $urandom_range(0, (MEM_WORDS * 4 / ROW_BYTES) - 1);
				endcase
				word_off = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 7) :
					$urandom_range(0, ROW_BYTES / 4 - 1);
				x.immediate = row * ROW_BYTES + word_off * 4;
			end
		end else if (pick < 56) begin
			x.operation = OP_ADDI;
			if ($urandom_range(0, 9) < 7)
				x.immediate = $urandom_range(0, 2000) - 1000;
		end else begin
			x.operation = 4'($urandom_range(OP_ADD, OP_J));
			// equal compare operands now and then so branches go both ways
			if ((x.operation == OP_BEQ || x.operation == OP_BNE) && $urandom_range(0, 3) == 0)
				x.src1_index = x.dest_index;
		end
		return x;
	endfunction

	// One instruction transaction; valid stays high into the next call if no gap.
	task automatic send_instr(input instr_t x, input int gap);
		@(negedge clk);
		instr_ch.valid   <= 1'b1;
		instr_ch.payload <= x;
		@(posedge clk);
		while (!instr_ch.ready) @(posedge clk);
		items_sent++;
		if (gap > 0) begin
			@(negedge clk);
			instr_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic write_cfg(input cfg_idx_t idx, input logic [DLY_W-1:0] value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// Stop issuing and wait until every result is back and the pipe is empty.
	task automatic drain_results();
		@(negedge clk);
		instr_ch.valid <= 1'b0;
		while (results_seen != items_sent) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Result side back-pressure: long all-ready stretches mixed with random stalls.
	initial begin
		int hold;
		int stall;
		result_ch.ready = 1'b0;
		forever begin
			if ($urandom_range(0, 9) < 2) begin
				hold  = $urandom_range(40, 150);
				stall = 0;
			end else begin
				hold  = $urandom_range(1, 6);
				stall = pick_gap();
			end
			@(negedge clk);
			result_ch.ready <= 1'b1;
			repeat (hold - 1) @(negedge clk);
			if (stall > 0) begin
				@(negedge clk);
				result_ch.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
		end
	end

	// Transaction counts, coverage tallies and the no-progress watchdog.
	always @(posedge clk) begin
		if (result_ch.valid && result_ch.ready) begin
			results_seen <= results_seen + 1;
			if (result_ch.payload.dram_access) begin
				case (result_ch.payload.row_result)
					ROW_HIT:  row_hits <= row_hits + 1;
					ROW_COLD: row_colds <= row_colds + 1;
					default:  row_conflicts <= row_conflicts + 1;
				endcase
			end
			if (result_ch.payload.status != ST_OK)
				flagged <= flagged + 1;
		end
		if ((instr_ch.valid && instr_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t ns: no transaction for %0d cycles, %0d sent, %0d returned",
				$time, idle_cycles, items_sent, results_seen);
			$display("mips_subset_execute_dram_timing_test failed");
			$finish;
		end
	end

	initial begin
		logic [DLY_W-1:0] row_set;
		logic [DLY_W-1:0] col_set;
		int               gap;
		arst_n           = 1'b0;
		cfg_write        = 1'b0;
		cfg_index        = CFG_ROW_DELAY;
		cfg_data         = '0;
		instr_ch.valid   = 1'b0;
		instr_ch.payload = '0;
		hot_row          = ROW_W'($urandom_range(0, (MEM_WORDS * 4 / ROW_BYTES) - 1));
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part, reset delays (row 10, col 2). The first DRAM access is the
		// only cold open of the run. Sent right away: the memory sweep holds them off.
		send_instr(make_instr(OP_ADDI, 2, 0, 0, 32'h7FFF_FFFF, 0), pick_gap());
		send_instr(make_instr(OP_ADDI, 3, 0, 0, 32'd1, 0), pick_gap());
		send_instr(make_instr(OP_ADDI, 5, 0, 0, 32'h8000_0000, 0), pick_gap());
		// overflow on each of add, sub, mul, addi
		send_instr(make_instr(OP_ADD, 4, 2, 3, 0, 0), pick_gap());
		send_instr(make_instr(OP_SUB, 6, 5, 3, 0, 0), pick_gap());
		send_instr(make_instr(OP_MUL, 7, 2, 2, 0, 0), pick_gap());
		send_instr(make_instr(OP_ADDI, 8, 2, 0, 32'd1, 0), pick_gap());
		send_instr(make_instr(OP_SLT, 9, 5, 2, 0, 0), pick_gap());
		// most negative times one: at the edge, no overflow
		send_instr(make_instr(OP_MUL, 10, 5, 3, 0, 0), pick_gap());
		// reserved destinations
		send_instr(make_instr(OP_ADD, RSV_ZERO, 2, 3, 0, 0), pick_gap());
		send_instr(make_instr(OP_SUB, RSV_AT, 2, 3, 0, 0), pick_gap());
		send_instr(make_instr(OP_ADDI, RSV_K1, 2, 0, 32'd5, 0), pick_gap());
		// cold open at the top word, hit, conflict back at row 0, hit on an unwritten word;
		// the load into register zero is allowed
		send_instr(make_instr(OP_SW, 2, 0, 0, MEM_WORDS * 4 - 4, 0), pick_gap());
		send_instr(make_instr(OP_LW, RSV_ZERO, 0, 0, MEM_WORDS * 4 - 4, 0), pick_gap());
		send_instr(make_instr(OP_SW, 5, 0, 0, 32'd0, 0), pick_gap());
		send_instr(make_instr(OP_LW, 11, 0, 0, 32'd4, 0), pick_gap());
		// invalid addresses: past the end, negative, unaligned
		send_instr(make_instr(OP_LW, 12, 0, 0, MEM_WORDS * 4, 0), pick_gap());
		send_instr(make_instr(OP_SW, 2, 0, 0, -32'sd4, 0), pick_gap());
		send_instr(make_instr(OP_LW, 12, 0, 0, 32'd2, 0), pick_gap());
		// branch to the last index, then a not-taken branch wraps the pc to zero
		send_instr(make_instr(OP_BEQ, 2, 2, 0, 0, 16'hFFFF), pick_gap());
		send_instr(make_instr(OP_BEQ, 2, 3, 0, 0, 16'h0000), pick_gap());
		send_instr(make_instr(OP_BNE, 2, 3, 0, 0, 16'h1234), pick_gap());
		send_instr(make_instr(OP_BNE, 3, 3, 31, 32'hFFFF_FFFF, 16'hFFFF), pick_gap());
		send_instr(make_instr(OP_J, 31, 31, 31, 0, 16'hABCD), pick_gap());
		send_instr(make_instr(OP_UNDEF_LO, 31, 31, 31, 32'hFFFF_FFFF, 16'hFFFF), pick_gap());
		send_instr(make_instr(OP_UNDEF_HI, 0, 0, 0, 0, 0), pick_gap());

		// Random part, one block per timing setting; first block keeps the reset
		// values, then both extremes, mixed extremes and a random pair.
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			if (phase > 0) begin
				drain_results();
				case (phase)
					1: begin row_set = 8'd1;   col_set = 8'd1;   end
					2: begin row_set = 8'd255; col_set = 8'd255; end
					3: begin row_set = 8'd255; col_set = 8'd1;   end
					4: begin row_set = 8'd1;   col_set = 8'd255; end
					default: begin
						row_set = DLY_W'($urandom_range(1, 255));
						col_set = DLY_W'($urandom_range(1, 255));
					end
				endcase
				write_cfg(CFG_ROW_DELAY, row_set);
				write_cfg(CFG_COL_DELAY, col_set);
			end
			for (int n = 0; n < RANDOM_ITEMS; n++) begin
				if (n % 30 == 0)
					hot_row = ROW_W'($urandom_range(0, (MEM_WORDS * 4 / ROW_BYTES) - 1));
				// a stretch with back-to-back instructions in every phase
				gap = (n >= 60 && n < 90) ? 0 : pick_gap();
				send_instr(random_instr(), gap);
			end
		end
		drain_results();

		$display("Ran %0d instructions over %0d row/column delay settings, %0d results checked",
			items_sent, NUM_PHASES, results_seen);
		$display("DRAM accesses: %0d hits, %0d cold opens, %0d conflicts; %0d error statuses",
			row_hits, row_colds, row_conflicts, flagged);
		if (pending != 0)
			$display("%0t ns: %0d expected results never returned", $time, pending);
		if (mismatches == 0 && pending == 0) begin
			$display("mips_subset_execute_dram_timing_test passed");
		end else begin
			$display("mips_subset_execute_dram_timing_test failed");
		end
		$finish;
	end

endmodule
